>>> rtl/core/etpq_pkg.sv
// Shared types and constants for the event time priority queue.
`timescale 1ns / 1ps

package etpq_pkg;

  localparam int QueueDepth = 64;
  localparam int IdxW       = $clog2(QueueDepth);
  localparam int CntW       = $clog2(QueueDepth + 1);
  localparam int TimeW      = 16;
  localparam int TagW       = 8;
  localparam int DelayW     = 12;
  localparam logic [TimeW-1:0] LimitReset = 16'd1000;
  localparam logic [TimeW-1:0] TimeMax    = '1;

  typedef struct packed {
    logic [TimeW-1:0] ev_time;
    logic [TagW-1:0]  person;
    logic             kind;
  } entry_t;

  typedef enum logic [2:0] {
    ST_EVENT    = 3'd0,
    ST_TERM     = 3'd1,
    ST_OVERRUN  = 3'd2,
    ST_FULL     = 3'd3,
    ST_RECORD   = 3'd4
  } status_e;

  typedef enum logic {
    KIND_ARRIVAL = 1'b0,
    KIND_DEPART  = 1'b1
  } kind_e;

  // Which result is loaded into the output register
  typedef enum logic [2:0] {
    RES_EVENT,
    RES_EMPTY,
    RES_HALTED,
    RES_OVERRUN,
    RES_FULL,
    RES_RECORD
  } res_e;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_INS_ARR,
    OP_INS_DEP,
    OP_POP
  } op_e;

  typedef enum logic {
    S_IDLE,
    S_DEPART
  } state_e;

  typedef struct packed {
    logic load_out;
    res_e res;
    op_e  op;
  } ctrl_cmd_t;

  typedef struct packed {
    logic halted;
    logic empty;
    logic full;
    logic head_over;
  } dp_status_t;

endpackage

>>> rtl/core/etpq_ctrl.sv
// Controller: accepts items, sequences the two inserts of a record, owns output valid.
`timescale 1ns / 1ps

module etpq_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                mode_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  etpq_pkg::dp_status_t sts_i,
  output etpq_pkg::ctrl_cmd_t  cmd_o
);

  etpq_pkg::state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= etpq_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    cmd_o.load_out = 1'b0;
    cmd_o.res    = etpq_pkg::RES_EVENT;
    cmd_o.op     = etpq_pkg::OP_NONE;
    in_stall_o   = 1'b1;
    accept       = 1'b0;
    unique case (state_q)
      etpq_pkg::S_IDLE: begin
        // the output slot is free unless a result sits there and is not taken now
        in_stall_o = out_valid_q && out_stall_i;
        accept     = in_valid_i && !in_stall_o;
        if (accept) begin
          cmd_o.load_out = 1'b1;
          priority if (sts_i.halted) begin
            cmd_o.res = etpq_pkg::RES_HALTED;
          end else if (mode_i == 1'b0) begin
            if (sts_i.full) begin
              cmd_o.res = etpq_pkg::RES_FULL;
            end else begin
              cmd_o.res = etpq_pkg::RES_RECORD;
              cmd_o.op  = etpq_pkg::OP_INS_ARR;
              state_d   = etpq_pkg::S_DEPART;
            end
          end else if (sts_i.empty) begin
            cmd_o.res = etpq_pkg::RES_EMPTY;
          end else begin
            cmd_o.op  = etpq_pkg::OP_POP;
            cmd_o.res = sts_i.head_over ? etpq_pkg::RES_OVERRUN : etpq_pkg::RES_EVENT;
          end
        end
      end
      etpq_pkg::S_DEPART: begin
        cmd_o.op = etpq_pkg::OP_INS_DEP;
        state_d  = etpq_pkg::S_IDLE;
      end
      default: state_d = etpq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

  a_depart_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.op == etpq_pkg::OP_INS_ARR |=> cmd_o.op == etpq_pkg::OP_INS_DEP)
    else $error("departure insert did not follow arrival insert");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.op == etpq_pkg::OP_POP |-> !sts_i.empty && !sts_i.halted)
    else $error("pop issued on empty or halted queue");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |-> !cmd_o.load_out)
    else $error("stalled result overwritten");

endmodule

>>> rtl/core/etpq_dp.sv
// Datapath: sorted row of queue cells, clocks, limit register and result register.
`timescale 1ns / 1ps

module etpq_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  etpq_pkg::ctrl_cmd_t          cmd_i,
  output etpq_pkg::dp_status_t         sts_o,
  input  logic [etpq_pkg::TagW-1:0]    person_tag_i,
  input  logic [etpq_pkg::DelayW-1:0]  depart_delay_i,
  input  logic [etpq_pkg::DelayW-1:0]  arrival_gap_i,
  input  logic                         cfg_we_i,
  input  logic [etpq_pkg::TimeW-1:0]   cfg_wdata_i,
  output logic [2:0]                   status_o,
  output logic [etpq_pkg::TimeW-1:0]   event_time_o,
  output logic [etpq_pkg::TagW-1:0]    event_person_o,
  output logic                         event_kind_o
);

  etpq_pkg::entry_t cells_q [etpq_pkg::QueueDepth];
  etpq_pkg::entry_t cells_d [etpq_pkg::QueueDepth];
  logic [etpq_pkg::QueueDepth-1:0] lt;

  logic [etpq_pkg::CntW-1:0]  count_q, count_d;
  logic [etpq_pkg::TimeW-1:0] arr_clk_q, arr_clk_d;
  logic [etpq_pkg::TimeW-1:0] sim_clk_q, sim_clk_d;
  logic [etpq_pkg::TimeW-1:0] limit_q;
  logic                       halted_q, halted_d;
  logic [etpq_pkg::TimeW-1:0] dep_time_q;
  logic [etpq_pkg::TagW-1:0]  dep_tag_q;

  logic [etpq_pkg::TimeW:0]   arr_sum, dep_sum;
  logic [etpq_pkg::TimeW-1:0] arr_next, dep_next;
  etpq_pkg::entry_t           new_ent, head;
  logic                       do_ins;

  logic [2:0]                 status_q;
  logic [etpq_pkg::TimeW-1:0] time_q;
  logic [etpq_pkg::TagW-1:0]  person_q;
  logic                       kind_q;

  assign head = cells_q[0];

  assign arr_sum  = {1'b0, arr_clk_q} + (etpq_pkg::TimeW+1)'(arrival_gap_i);
  assign dep_sum  = {1'b0, arr_clk_q} + (etpq_pkg::TimeW+1)'(depart_delay_i);
  assign arr_next = arr_sum[etpq_pkg::TimeW] ? etpq_pkg::TimeMax
                                             : arr_sum[etpq_pkg::TimeW-1:0];
  assign dep_next = dep_sum[etpq_pkg::TimeW] ? etpq_pkg::TimeMax
                                             : dep_sum[etpq_pkg::TimeW-1:0];

  assign sts_o.halted    = halted_q;
  assign sts_o.empty     = (count_q == '0);
  assign sts_o.full      = (count_q > etpq_pkg::CntW'(etpq_pkg::QueueDepth - 2));
  assign sts_o.head_over = (head.ev_time > limit_q);

  always_comb begin
    new_ent.ev_time = arr_clk_q;
    new_ent.person  = person_tag_i;
    new_ent.kind    = etpq_pkg::KIND_ARRIVAL;
    do_ins          = 1'b0;
    unique case (cmd_i.op)
      etpq_pkg::OP_INS_ARR: do_ins = 1'b1;
      etpq_pkg::OP_INS_DEP: begin
        do_ins          = 1'b1;
        new_ent.ev_time = dep_time_q;
        new_ent.person  = dep_tag_q;
        new_ent.kind    = etpq_pkg::KIND_DEPART;
      end
      etpq_pkg::OP_POP, etpq_pkg::OP_NONE: ;
      default: ;
    endcase
  end

  // Each live cell older than the new event keeps its place; ties push the old one back.
  always_comb begin
    for (int i = 0; i < etpq_pkg::QueueDepth; i++) begin
      lt[i] = (etpq_pkg::CntW'(i) < count_q) && (cells_q[i].ev_time < new_ent.ev_time);
    end
  end

  always_comb begin
    for (int i = 0; i < etpq_pkg::QueueDepth; i++) begin
      cells_d[i] = cells_q[i];
      if (do_ins) begin
        priority if (lt[i]) begin
          cells_d[i] = cells_q[i];
        end else if (i == 0) begin
          cells_d[i] = new_ent;
        end else if (lt[i-1]) begin
          cells_d[i] = new_ent;
        end else begin
          cells_d[i] = cells_q[i-1];
        end
      end else if (cmd_i.op == etpq_pkg::OP_POP && i < etpq_pkg::QueueDepth - 1) begin
        cells_d[i] = cells_q[i+1];
      end
    end
  end

  always_comb begin
    count_d   = count_q;
    arr_clk_d = arr_clk_q;
    sim_clk_d = sim_clk_q;
    halted_d  = halted_q;
    if (do_ins) begin
      count_d = count_q + 1'b1;
    end
    if (cmd_i.op == etpq_pkg::OP_INS_ARR) begin
      arr_clk_d = arr_next;
    end
    if (cmd_i.op == etpq_pkg::OP_POP) begin
      count_d = count_q - 1'b1;
      if (sts_o.head_over) begin
        halted_d = 1'b1;
      end else begin
        sim_clk_d = head.ev_time;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      arr_clk_q <= '0;
      sim_clk_q <= '0;
      halted_q  <= 1'b0;
      limit_q   <= etpq_pkg::LimitReset;
    end else begin
      count_q   <= count_d;
      arr_clk_q <= arr_clk_d;
      sim_clk_q <= sim_clk_d;
      halted_q  <= halted_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cells_q <= cells_d;
    if (cmd_i.op == etpq_pkg::OP_INS_ARR) begin
      dep_time_q <= dep_next;
      dep_tag_q  <= person_tag_i;
    end
    if (cmd_i.load_out) begin
      unique case (cmd_i.res)
        etpq_pkg::RES_EVENT: begin
          status_q <= etpq_pkg::ST_EVENT;
          time_q   <= head.ev_time;
          person_q <= head.person;
          kind_q   <= head.kind;
        end
        etpq_pkg::RES_OVERRUN: begin
          status_q <= etpq_pkg::ST_OVERRUN;
          time_q   <= head.ev_time;
          person_q <= head.person;
          kind_q   <= head.kind;
        end
        etpq_pkg::RES_EMPTY: begin
          status_q <= etpq_pkg::ST_TERM;
          time_q   <= sim_clk_q;
          person_q <= '0;
          kind_q   <= 1'b0;
        end
        etpq_pkg::RES_HALTED: begin
          status_q <= etpq_pkg::ST_OVERRUN;
          time_q   <= sim_clk_q;
          person_q <= '0;
          kind_q   <= 1'b0;
        end
        etpq_pkg::RES_FULL: begin
          status_q <= etpq_pkg::ST_FULL;
          time_q   <= arr_clk_q;
          person_q <= person_tag_i;
          kind_q   <= 1'b0;
        end
        etpq_pkg::RES_RECORD: begin
          status_q <= etpq_pkg::ST_RECORD;
          time_q   <= arr_clk_q;
          person_q <= person_tag_i;
          kind_q   <= 1'b0;
        end
        default: begin
          status_q <= etpq_pkg::ST_OVERRUN;
          time_q   <= sim_clk_q;
          person_q <= '0;
          kind_q   <= 1'b0;
        end
      endcase
    end
  end

  assign status_o       = status_q;
  assign event_time_o   = time_q;
  assign event_person_o = person_q;
  assign event_kind_o   = kind_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= etpq_pkg::CntW'(etpq_pkg::QueueDepth))
    else $error("entry count beyond queue depth");

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> halted_q && $stable(count_q))
    else $error("halted queue changed");

  a_ins_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_ins |-> count_q < etpq_pkg::CntW'(etpq_pkg::QueueDepth))
    else $error("insert into full queue");

endmodule

>>> rtl/core/event_time_priority_queue_top.sv
// Top level of the event time priority queue: controller plus datapath.
`timescale 1ns / 1ps

// Channel | Handshake              | Payload
// input   | in_valid_i / in_stall_o | mode_i, person_tag_i, depart_delay_i, arrival_gap_i
// output  | out_valid_o / out_stall_i | status_o, event_time_o, event_person_o, event_kind_o
// config  | cfg_we_i                | cfg_wdata_i (time_limit)
//
// An accepted record has its arrival and then its departure shifted into the sorted cell
// row, the departure in state S_DEPART, which holds the input off. The result sits in the
// output register from the cycle after its item is taken; the next item is taken no
// earlier than the cycle that result is read, so a stalled result holds the input off.
// Reset is asynchronous, active low; it empties the queue logically, the cells themselves
// are not cleared.

module event_time_priority_queue_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         mode_i,
  input  logic [etpq_pkg::TagW-1:0]    person_tag_i,
  input  logic [etpq_pkg::DelayW-1:0]  depart_delay_i,
  input  logic [etpq_pkg::DelayW-1:0]  arrival_gap_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [2:0]                   status_o,
  output logic [etpq_pkg::TimeW-1:0]   event_time_o,
  output logic [etpq_pkg::TagW-1:0]    event_person_o,
  output logic                         event_kind_o,
  input  logic                         cfg_we_i,
  input  logic [etpq_pkg::TimeW-1:0]   cfg_wdata_i
);

  etpq_pkg::ctrl_cmd_t  cmd;
  etpq_pkg::dp_status_t sts;

  etpq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  etpq_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .person_tag_i   (person_tag_i),
    .depart_delay_i (depart_delay_i),
    .arrival_gap_i  (arrival_gap_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .status_o       (status_o),
    .event_time_o   (event_time_o),
    .event_person_o (event_person_o),
    .event_kind_o   (event_kind_o)
  );

endmodule

>>> dv/tb.sv
// Testbench for the event time priority queue: items checked against a queue model.
`timescale 1ns / 1ps

module tb;

  localparam logic MODE_RECORD = 1'b0;
  localparam logic MODE_POP    = 1'b1;

  typedef struct {
    etpq_pkg::status_e status;
    logic [15:0]       ev_time;
    logic [7:0]        person;
    logic              kind;
  } result_t;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic        in_stall_o;
  logic        mode_i         = MODE_RECORD;
  logic [7:0]  person_tag_i   = '0;
  logic [11:0] depart_delay_i = '0;
  logic [11:0] arrival_gap_i  = '0;
  logic        out_valid_o;
  logic        out_stall_i    = 1'b0;
  logic [2:0]  status_o;
  logic [15:0] event_time_o;
  logic [7:0]  event_person_o;
  logic        event_kind_o;
  logic        cfg_we_i       = 1'b0;
  logic [15:0] cfg_wdata_i    = '0;

  // Queue model state
  etpq_pkg::entry_t model_events[$];
  logic [15:0] arr_clock = '0;
  logic [15:0] sim_now   = '0;
  logic [15:0] limit_cfg = etpq_pkg::LimitReset;
  logic        halted_m  = 1'b0;

  result_t     expected_results[$];
  int unsigned error_count = 0;
  bit          tx_idle     = 1'b0;
  bit          rx_idle     = 1'b0;
  int unsigned rx_hold     = 0;

  event_time_priority_queue_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .mode_i        (mode_i),
    .person_tag_i  (person_tag_i),
    .depart_delay_i(depart_delay_i),
    .arrival_gap_i (arrival_gap_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .event_time_o  (event_time_o),
    .event_person_o(event_person_o),
    .event_kind_o  (event_kind_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [15:0] sat_time(logic [15:0] base, logic [11:0] step);
    logic [16:0] sum;
    sum = {1'b0, base} + {5'b0, step};
    return sum[16] ? etpq_pkg::TimeMax : sum[15:0];
  endfunction

  // Newest event goes ahead of any queued event with the same time
  function automatic void insert_event(logic [15:0] t, logic [7:0] tag,
                                       etpq_pkg::kind_e kind);
    etpq_pkg::entry_t e;
    int               pos;
    e.ev_time = t;
    e.person  = tag;
    e.kind    = kind;
    pos = 0;
    while (pos < model_events.size() && model_events[pos].ev_time < t) pos++;
    model_events.insert(pos, e);
  endfunction

  function automatic result_t predict_event_result(logic mode, logic [7:0] tag,
                                                   logic [11:0] delay, logic [11:0] gap);
    result_t          r;
    etpq_pkg::entry_t head;
    r.status  = etpq_pkg::ST_EVENT;
    r.ev_time = '0;
    r.person  = '0;
    r.kind    = etpq_pkg::KIND_ARRIVAL;
    if (halted_m) begin
      r.status  = etpq_pkg::ST_OVERRUN;
      r.ev_time = sim_now;
    end else if (mode == MODE_RECORD) begin
      r.ev_time = arr_clock;
      r.person  = tag;
      if (model_events.size() + 2 > etpq_pkg::QueueDepth) begin
        r.status = etpq_pkg::ST_FULL;
      end else begin
        insert_event(arr_clock, tag, etpq_pkg::KIND_ARRIVAL);
        insert_event(sat_time(arr_clock, delay), tag, etpq_pkg::KIND_DEPART);
        arr_clock = sat_time(arr_clock, gap);
        r.status  = etpq_pkg::ST_RECORD;
      end
    end else if (model_events.size() == 0) begin
      r.status  = etpq_pkg::ST_TERM;
      r.ev_time = sim_now;
    end else begin
      head      = model_events.pop_front();
      r.ev_time = head.ev_time;
      r.person  = head.person;
      r.kind    = head.kind;
      if (head.ev_time > limit_cfg) begin
        halted_m = 1'b1;
        r.status = etpq_pkg::ST_OVERRUN;
      end else begin
        sim_now  = head.ev_time;
        r.status = etpq_pkg::ST_EVENT;
      end
    end
    return r;
  endfunction

  // Entered and left at a falling edge; valid stays high when the next item follows at once
  task automatic send_item(logic mode, logic [7:0] tag, logic [11:0] delay, logic [11:0] gap);
    int unsigned wait_cycles;
    wait_cycles = tx_idle ? $urandom_range(19, 0) : 0;
    if (wait_cycles != 0) begin
      in_valid_i <= 1'b0;
      repeat (wait_cycles) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    mode_i         <= mode;
    person_tag_i   <= tag;
    depart_delay_i <= delay;
    arrival_gap_i  <= gap;
    do @(posedge clk_i); while (in_stall_o);
    expected_results.push_back(predict_event_result(mode, tag, delay, gap));
    @(negedge clk_i);
  endtask

  task automatic send_record(logic [7:0] tag, logic [11:0] delay, logic [11:0] gap);
    send_item(MODE_RECORD, tag, delay, gap);
  endtask

  task automatic send_pop();
    send_item(MODE_POP, 8'($urandom), 12'($urandom), 12'($urandom));
  endtask

  task automatic drain_model();
    while (model_events.size() != 0) send_pop();
  endtask

  // An accepted record may still be inserting its departure after the result is out
  task automatic settle();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_limit(logic [15:0] value);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    limit_cfg = value;
  endtask

  task automatic test_empty_pop();
    send_pop();
  endtask

  // Departure exactly at the reset limit still counts as in range
  task automatic test_reset_limit();
    send_record(8'h00, 12'd1000, 12'd0);
    send_pop();
    send_pop();
    send_pop();
  endtask

  // Zero delay: departure is queued after the arrival and so pops first
  task automatic test_limit_zero();
    write_limit(16'd0);
    send_record(8'hFF, 12'd0, 12'd0);
    send_pop();
    send_pop();
    write_limit(etpq_pkg::TimeMax);
  endtask

  task automatic test_field_extremes();
    send_record(8'hFF, 12'hFFF, 12'hFFF);
    send_record(8'h00, 12'h000, 12'h000);
    send_record(8'hA5, 12'h555, 12'hAAA);
    send_record(8'h5A, 12'hAAA, 12'h555);
    drain_model();
    send_pop();
  endtask

  task automatic test_queue_full();
    while (model_events.size() + 2 <= etpq_pkg::QueueDepth)
      send_record(8'($urandom), 12'($urandom), 12'($urandom_range(3, 0)));
    send_record(8'($urandom), 12'($urandom), 12'($urandom));
    send_pop();
    send_record(8'($urandom), 12'($urandom), 12'($urandom));
    drain_model();
    send_pop();
  endtask

  task automatic test_random_traffic();
    int unsigned record_pct;
    for (int chunk = 0; chunk < 5; chunk++) begin
      tx_idle    = $urandom_range(3, 0) != 0;
      rx_idle    = $urandom_range(3, 0) != 0;
      record_pct = $urandom_range(70, 30);
      for (int k = 0; k < 50; k++) begin
        if ($urandom_range(99, 0) < record_pct)
          send_record(8'($urandom), 12'($urandom),
                      12'(($urandom_range(99, 0) < 3) ? $urandom_range(4095, 0)
                                                       : $urandom_range(15, 0)));
        else
          send_pop();
      end
    end
  endtask

  // Receiver holds off while items keep coming, so the block backs up
  task automatic test_backpressure();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    rx_hold = 300;
    repeat (40) begin
      if ($urandom_range(1, 0) == 0)
        send_record(8'($urandom), 12'($urandom), 12'($urandom_range(15, 0)));
      else send_pop();
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  task automatic test_saturation();
    while (arr_clock != etpq_pkg::TimeMax) begin
      if (model_events.size() + 2 > etpq_pkg::QueueDepth) send_pop();
      send_record(8'($urandom), 12'hFFF, 12'hFFF);
    end
    send_record(8'($urandom), 12'($urandom), 12'($urandom));
    drain_model();
  endtask

  // Must run last: only reset clears the halt
  task automatic test_overrun_halt();
    send_record(8'($urandom), 12'($urandom), 12'($urandom));
    write_limit(16'($urandom_range(etpq_pkg::TimeMax - 1, 1)));
    send_pop();
    repeat (6) send_item(1'($urandom), 8'($urandom), 12'($urandom), 12'($urandom));
  endtask

  initial begin
    int unsigned stall_cycles;
    @(negedge clk_i);
    forever begin
      stall_cycles = (rx_idle ? $urandom_range(19, 0) : 0) + rx_hold;
      rx_hold = 0;
      if (stall_cycles != 0) begin
        out_stall_i <= 1'b1;
        repeat (stall_cycles) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    result_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("tb: unexpected result: status %0d time %0d person %0d kind %0d",
                   status_o, event_time_o, event_person_o, event_kind_o);
      end else begin
        exp_r = expected_results.pop_front();
        if (status_o !== exp_r.status || event_time_o !== exp_r.ev_time ||
            event_person_o !== exp_r.person || event_kind_o !== exp_r.kind) begin
          error_count++;
          if (error_count <= 10)
            $display("tb: mismatch: exp status %0d time %0d person %0d kind %0d, %s",
                     exp_r.status, exp_r.ev_time, exp_r.person, exp_r.kind,
                     $sformatf("got status %0d time %0d person %0d kind %0d",
                               status_o, event_time_o, event_person_o, event_kind_o));
        end
      end
    end
  end

  initial begin
    #3000000;
    $display("tb: FAIL");
    $finish;
  end

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_empty_pop();
    test_reset_limit();
    test_limit_zero();
    test_field_extremes();
    test_queue_full();
    test_random_traffic();
    test_backpressure();
    test_saturation();
    test_overrun_halt();
    settle();
    repeat (16) @(negedge clk_i);
    error_count += expected_results.size();
    if (error_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
